// File: design/owrs_pkg.sv
// ----------------------------------------------------------------------------
// owrs_pkg
// Shared types and constants for the 1-Wire ROM search sequencer.
// ----------------------------------------------------------------------------
package owrs_pkg;

  // Bus event kinds on the input stream
  typedef enum logic [1:0] {
    CMD_START    = 2'd0,
    CMD_PRESENCE = 2'd1,
    CMD_PAIR     = 2'd2,
    CMD_ROM      = 2'd3
  } cmd_t;

  // Requests and reports on the output stream
  typedef enum logic [2:0] {
    ACT_RESET    = 3'd0,
    ACT_WRCMD    = 3'd1,
    ACT_READPAIR = 3'd2,
    ACT_WRBIT    = 3'd3,
    ACT_READROM  = 3'd4,
    ACT_FOUND    = 3'd5,
    ACT_FINISH   = 3'd6
  } action_t;

  // Sequencer phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PRES = 2'd1,
    PH_PAIR = 2'd2,
    PH_ROM  = 2'd3
  } phase_t;

  // Register index (paddr[2])
  localparam logic REG_MAX_DEVICES = 1'b0;
  localparam logic REG_SEARCH_CMD  = 1'b1;

  localparam logic [7:0]        MAX_DEV_RESET    = 8'd10;
  localparam logic [7:0]        SEARCH_CMD_RESET = 8'hF0;
  localparam logic [7:0]        READ_ROM_CMD     = 8'h33;
  localparam logic [7:0]        CRC_POLY         = 8'h8C;
  localparam logic signed [7:0] BRANCH_NONE      = 8'sd64;
  localparam logic signed [6:0] LZ_NONE          = -7'sd1;

  typedef struct packed {
    logic [7:0] max_devices;
    logic [7:0] search_command;
  } cfg_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        no_presence;
    logic        id_bit;
    logic        cpl_bit;
    logic [63:0] rom_value;
  } item_t;

  typedef struct packed {
    action_t     action;
    logic        bit_value;
    logic [7:0]  command_byte;
    logic [63:0] device_code;
    logic        crc_ok;
  } res_t;

  // Up to three results caused by one event
  typedef struct packed {
    logic [1:0]     count;
    res_t [2:0]     res;
  } bundle_t;

endpackage

// File: design/owrs_core.sv
// ----------------------------------------------------------------------------
// owrs_core
// Search state and single-pass next-state logic; builds the result bundle.
// ----------------------------------------------------------------------------
module owrs_core
  import owrs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output bundle_t bundle
);

  phase_t             phase, phase_next;
  logic [63:0]        prev_code, prev_code_next;
  logic [63:0]        cur_code, cur_code_next;
  logic signed [7:0]  branch_mark, branch_mark_next;
  logic signed [6:0]  zero_pos, zero_pos_next;
  logic [5:0]         bit_pos, bit_pos_next;
  logic [7:0]         passes, passes_next;
  logic               final_seen, final_seen_next;

  logic [63:0]        code_new;
  logic               dir;
  logic               pass_ok;

  // Dallas CRC8 of the low seven bytes, compared with the top byte
  function automatic logic crc_match(input logic [63:0] code);
    logic [7:0] crc;
    crc = '0;
    for (int b = 0; b < 56; b++) begin
      if (crc[0] ^ code[b]) crc = (crc >> 1) ^ CRC_POLY;
      else                  crc = crc >> 1;
    end
    return crc == code[63:56];
  endfunction

  // Preferred direction at a bit position
  function automatic logic search_dir(input logic [5:0] pos,
                                      input logic signed [7:0] bm,
                                      input logic [63:0] prev);
    logic signed [7:0] p;
    p = signed'({2'b00, pos});
    if (p == bm)     return 1'b1;
    else if (p > bm) return 1'b0;
    else             return prev[pos];
  endfunction

  function automatic res_t mk_res(input action_t a, input logic b,
                                  input logic [7:0] cb);
    res_t r;
    r              = '0;
    r.action       = a;
    r.bit_value    = b;
    r.command_byte = cb;
    return r;
  endfunction

  function automatic res_t mk_found(input logic [63:0] code);
    res_t r;
    r             = '0;
    r.action      = ACT_FOUND;
    r.device_code = code;
    r.crc_ok      = crc_match(code);
    return r;
  endfunction

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      prev_code   <= '0;
      cur_code    <= '0;
      branch_mark <= BRANCH_NONE;
      zero_pos    <= LZ_NONE;
      bit_pos     <= '0;
      passes      <= '0;
      final_seen  <= 1'b0;
    end else if (fire) begin
      phase       <= phase_next;
      prev_code   <= prev_code_next;
      cur_code    <= cur_code_next;
      branch_mark <= branch_mark_next;
      zero_pos    <= zero_pos_next;
      bit_pos     <= bit_pos_next;
      passes      <= passes_next;
      final_seen  <= final_seen_next;
    end
  end

  // Next state and results for one event
  always_comb begin
    phase_next       = phase;
    prev_code_next   = prev_code;
    cur_code_next    = cur_code;
    branch_mark_next = branch_mark;
    zero_pos_next    = zero_pos;
    bit_pos_next     = bit_pos;
    passes_next      = passes;
    final_seen_next  = final_seen;
    bundle           = '0;
    code_new         = cur_code;
    dir              = 1'b0;
    pass_ok          = 1'b0;

    unique case (item.cmd)
      CMD_START: begin
        branch_mark_next = BRANCH_NONE;
        zero_pos_next    = LZ_NONE;
        bit_pos_next     = '0;
        final_seen_next  = 1'b0;
        prev_code_next   = '0;
        cur_code_next    = '0;
        bundle.count     = 2'd1;
        if (cfg.max_devices != 8'd0) begin
          passes_next   = 8'd1;
          bundle.res[0] = mk_res(ACT_RESET, 1'b0, 8'd0);
          phase_next    = PH_PRES;
        end else begin
          passes_next   = '0;
          bundle.res[0] = mk_res(ACT_FINISH, 1'b0, 8'd0);
          phase_next    = PH_IDLE;
        end
      end

      CMD_PRESENCE: begin
        if (phase == PH_PRES) begin
          if (item.no_presence) begin
            bundle.count  = 2'd1;
            bundle.res[0] = mk_res(ACT_FINISH, 1'b0, 8'd0);
            phase_next    = PH_IDLE;
          end else if (cfg.max_devices == 8'd1) begin
            bundle.count  = 2'd2;
            bundle.res[0] = mk_res(ACT_WRCMD, 1'b0, READ_ROM_CMD);
            bundle.res[1] = mk_res(ACT_READROM, 1'b0, 8'd0);
            phase_next    = PH_ROM;
          end else begin
            bit_pos_next  = '0;
            bundle.count  = 2'd2;
            bundle.res[0] = mk_res(ACT_WRCMD, 1'b0, cfg.search_command);
            bundle.res[1] = mk_res(ACT_READPAIR,
                                   search_dir(6'd0, branch_mark, prev_code), 8'd0);
            phase_next    = PH_PAIR;
          end
        end
      end

      CMD_PAIR: begin
        if (phase == PH_PAIR) begin
          if (item.id_bit && item.cpl_bit) begin
            // pass dropped: partial code becomes the previous one if another pass follows
            bundle.count = 2'd1;
            if (!final_seen && passes < cfg.max_devices) begin
              passes_next    = 8'(passes + 8'd1);
              prev_code_next = cur_code;
              cur_code_next  = '0;
              bundle.res[0]  = mk_res(ACT_RESET, 1'b0, 8'd0);
              phase_next     = PH_PRES;
            end else begin
              bundle.res[0]  = mk_res(ACT_FINISH, 1'b0, 8'd0);
              phase_next     = PH_IDLE;
            end
          end else begin
            if (!item.id_bit && !item.cpl_bit) begin
              dir = search_dir(bit_pos, branch_mark, prev_code);
              if (!dir) zero_pos_next = signed'({1'b0, bit_pos});
            end else begin
              dir = item.id_bit;
            end
            code_new      = cur_code | ({63'd0, dir} << bit_pos);
            cur_code_next = code_new;
            bundle.res[0] = mk_res(ACT_WRBIT, dir, 8'd0);
            if (bit_pos != 6'd63) begin
              bit_pos_next  = 6'(bit_pos + 6'd1);
              bundle.count  = 2'd2;
              bundle.res[1] = mk_res(ACT_READPAIR,
                                     search_dir(6'(bit_pos + 6'd1), branch_mark, prev_code),
                                     8'd0);
            end else begin
              // code complete: update discrepancy tracking, report, then start another pass or finish
              final_seen_next  = final_seen
                                 | (branch_mark == {zero_pos_next[6], zero_pos_next})
                                 | zero_pos_next[6];
              branch_mark_next = {zero_pos_next[6], zero_pos_next};
              bundle.count     = 2'd3;
              bundle.res[1]    = mk_found(code_new);
              pass_ok          = !final_seen_next && passes < cfg.max_devices;
              if (pass_ok) begin
                passes_next    = 8'(passes + 8'd1);
                prev_code_next = code_new;
                cur_code_next  = '0;
                bundle.res[2]  = mk_res(ACT_RESET, 1'b0, 8'd0);
                phase_next     = PH_PRES;
              end else begin
                bundle.res[2]  = mk_res(ACT_FINISH, 1'b0, 8'd0);
                phase_next     = PH_IDLE;
              end
            end
          end
        end
      end

      CMD_ROM: begin
        if (phase == PH_ROM) begin
          cur_code_next = item.rom_value;
          phase_next    = PH_IDLE;
          if (item.rom_value != 64'd0) begin
            bundle.count  = 2'd2;
            bundle.res[0] = mk_found(item.rom_value);
            bundle.res[1] = mk_res(ACT_FINISH, 1'b0, 8'd0);
          end else begin
            bundle.count  = 2'd1;
            bundle.res[0] = mk_res(ACT_FINISH, 1'b0, 8'd0);
          end
        end
      end

      default: ;
    endcase
  end

endmodule

// File: design/owrs_outbuf.sv
// ----------------------------------------------------------------------------
// owrs_outbuf
// Result register: holds one bundle and sends its results one beat each.
// ----------------------------------------------------------------------------
module owrs_outbuf
  import owrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  bundle_t     bundle_in,
  output logic        load_ok,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // bit_value, command_byte, device_code, crc_ok, pad
  output logic [2:0]  m_tuser,   // action
  output logic        m_tlast
);

  bundle_t    bnd;
  logic       valid;
  logic [1:0] idx;
  logic       beat_last;
  res_t       cur;

  assign beat_last = idx == 2'(bnd.count - 2'd1);
  assign load_ok   = !valid || (m_tready && beat_last);
  assign cur       = bnd.res[idx];

  // Control: valid flag and beat index
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load && bundle_in.count != 2'd0) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (valid && m_tready) begin
      if (beat_last) valid <= 1'b0;
      else           idx   <= 2'(idx + 2'd1);
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) bnd <= bundle_in;
  end

  assign m_tvalid = valid;
  assign m_tdata  = {6'd0, cur.crc_ok, cur.device_code, cur.command_byte, cur.bit_value};
  assign m_tuser  = cur.action;
  assign m_tlast  = beat_last;

endmodule

// File: design/onewire_rom_search.sv
// ----------------------------------------------------------------------------
// onewire_rom_search
// 1-Wire ROM search sequencer: input register, search core, result register.
// ----------------------------------------------------------------------------
// Path: an event's first result beat goes through the input register, then the
//   result register; a busy result register holds the event in the input register.
// Throughput: one event per cycle when each event gives one result and m_tready is high;
//   an event giving up to three results holds the result register until its last beat goes.
// Reset: synchronous; clears search state and stream flags, and loads
//   max_devices = 10, search_command = 0xF0.
module onewire_rom_search
  import owrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // event stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // no_presence, id_bit, cpl_bit, rom_value[66:3], pad
  input  logic [1:0]  s_tuser,   // cmd
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // bit_value, command_byte, device_code, crc_ok, pad
  output logic [2:0]  m_tuser,   // action
  output logic        m_tlast,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  item_t   item;
  logic    in_valid;
  logic    fire;
  logic    load_ok;
  bundle_t bundle;

  // Registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_devices    <= MAX_DEV_RESET;
      cfg.search_command <= SEARCH_CMD_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_MAX_DEVICES: cfg.max_devices    <= pwdata[7:0];
        REG_SEARCH_CMD:  cfg.search_command <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MAX_DEVICES: prdata = {24'd0, cfg.max_devices};
      REG_SEARCH_CMD:  prdata = {24'd0, cfg.search_command};
      default:         prdata = '0;
    endcase
  end

  // Input register
  assign fire     = in_valid && load_ok;
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.cmd         <= cmd_t'(s_tuser);
      item.no_presence <= s_tdata[0];
      item.id_bit      <= s_tdata[1];
      item.cpl_bit     <= s_tdata[2];
      item.rom_value   <= s_tdata[66:3];
    end
  end

  owrs_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .cfg    (cfg),
    .bundle (bundle)
  );

  owrs_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .bundle_in (bundle),
    .load_ok   (load_ok),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// File: design/owrs_checker.sv
// ----------------------------------------------------------------------------
// owrs_checker
// Port-level checks on the result stream of the ROM search sequencer.
// ----------------------------------------------------------------------------
module owrs_checker
  import owrs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // No result beat right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat valid after reset");

  // Bus reset, pair read, ROM read and finish close an event's results;
  // command write, bit write and found never do
  a_last_by_action: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == ACT_RESET || m_tuser == ACT_READPAIR ||
                              m_tuser == ACT_READROM || m_tuser == ACT_FINISH)))
    else $error("tlast does not match action");

  // Code and CRC flag only carried by found beats
  a_code_only_found: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ACT_FOUND) |-> m_tdata[73:9] == '0)
    else $error("device code on a non-found beat");

  // Stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=>
      (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
    else $error("result beat changed while stalled");

endmodule

bind onewire_rom_search owrs_checker u_owrs_checker (.*);
